@@ rtl/ncov_pkg.sv @@
`timescale 1ns / 1ps

package ncov_pkg;

    // Field and accumulator widths.
    localparam int COORD_W       = 20;
    localparam int CNT_W         = 7;
    localparam int MAX_NEIGHBORS = 64;
    localparam int SUM_W         = 27;
    localparam int SQ_W          = 47;
    localparam int OUT_W         = 48;
    localparam int EIG_W         = 32;
    localparam int IDX_W         = 2;

    // Divider operand widths and step counter width.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 6;

    // Set queue depth.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_CNT_W = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MIN_NEIGHBORS   = 2'd0;
    localparam logic [IDX_W-1:0] REG_REGULARIZE_MODE = 2'd1;
    localparam logic [IDX_W-1:0] REG_EIG_SMALL       = 2'd2;
    localparam logic [IDX_W-1:0] REG_EIG_LARGE       = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0] RST_MIN_NEIGHBORS = 7'd10;
    localparam logic [EIG_W-1:0] RST_EIG_SMALL     = 32'd1049;
    localparam logic [EIG_W-1:0] RST_EIG_LARGE     = 32'd1048576;

    // 1.0 in Q28.20.
    localparam logic [OUT_W-1:0] ONE_Q20 = 48'h000000100000;

    // Output range in a 64-bit signed word.
    localparam logic signed [63:0] OUT_MAX = 64'sh00007FFFFFFFFFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000800000000000;

    // One finished neighbor set handed from the front to the back.
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SQ_W-1:0]  sum_xx;
        logic signed [SQ_W-1:0]  sum_xy;
        logic signed [SQ_W-1:0]  sum_yy;
    } set_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0] min_neighbors;
        logic             regularize_mode;
        logic [EIG_W-1:0] eig_small;
        logic [EIG_W-1:0] eig_large;
    } cfg_t;

    // Clamp a signed value to the 48-bit output range.
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic [OUT_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end
        else if (v < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end
        else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/ncov_front.sv @@
`timescale 1ns / 1ps

module ncov_front
    import ncov_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // coord_x [19:0], coord_y [39:20]
    input  logic                  s_tlast,   // last_neighbor
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    output logic                  push,
    output set_t                  push_data
);

    localparam int PROD_W = 2 * COORD_W;

    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic signed [PROD_W-1:0]  s1_xx_reg;
    logic signed [PROD_W-1:0]  s1_xy_reg;
    logic signed [PROD_W-1:0]  s1_yy_reg;

    set_t acc_reg;
    set_t acc_next;
    set_t acc_upd;

    logic                      accept;
    logic                      pend;
    logic [FIFO_CNT_W-1:0]     used;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;

    // A set closing in the product stage has a queue slot reserved.
    assign pend     = s1_valid_reg & s1_last_reg;
    assign used     = fifo_count + FIFO_CNT_W'(pend);
    assign s_tready = (used < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept   = s_tvalid & s_tready;

    assign in_x = signed'(s_tdata[COORD_W-1:0]);
    assign in_y = signed'(s_tdata[2*COORD_W-1:COORD_W]);

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg  <= in_x;
            s1_y_reg  <= in_y;
            s1_xx_reg <= PROD_W'(in_x) * PROD_W'(in_x);
            s1_xy_reg <= PROD_W'(in_x) * PROD_W'(in_y);
            s1_yy_reg <= PROD_W'(in_y) * PROD_W'(in_y);
        end
    end

    // Accumulate stage; words past the neighbor limit are dropped.
    always_comb
    begin
        acc_upd = acc_reg;
        if (s1_valid_reg && (acc_reg.count < CNT_W'(MAX_NEIGHBORS)))
        begin
            acc_upd.count  = acc_reg.count + 1'b1;
            acc_upd.sum_x  = acc_reg.sum_x + SUM_W'(s1_x_reg);
            acc_upd.sum_y  = acc_reg.sum_y + SUM_W'(s1_y_reg);
            acc_upd.sum_xx = acc_reg.sum_xx + SQ_W'(s1_xx_reg);
            acc_upd.sum_xy = acc_reg.sum_xy + SQ_W'(s1_xy_reg);
            acc_upd.sum_yy = acc_reg.sum_yy + SQ_W'(s1_yy_reg);
        end
        push      = pend;
        push_data = acc_upd;
        acc_next  = pend ? '0 : acc_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

@@ rtl/ncov_fifo.sv @@
`timescale 1ns / 1ps

module ncov_fifo
    import ncov_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  set_t                  push_data,
    input  logic                  pop,
    output set_t                  pop_data,
    output logic [FIFO_CNT_W-1:0] count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    set_t                  mem [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign count    = count_reg;
    assign pop_data = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/ncov_div.sv @@
`timescale 1ns / 1ps

module ncov_div
    import ncov_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_NUM_W-1:0] quo_next;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    // One restoring step: one quotient bit per cycle.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_next = fits ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
        quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ rtl/ncov_back.sv @@
`timescale 1ns / 1ps

module ncov_back
    import ncov_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    input  set_t                  pop_data,
    output logic                  pop,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [143:0]          m_tdata,   // cov_xx [47:0], cov_xy [95:48], cov_yy [143:96]
    output logic                  m_tuser    // corner_one
);

    localparam int NUMC_W = 56;
    localparam int DIFF_W = OUT_W + 1;
    localparam int NRM_W  = 29;
    localparam int RAD_W  = 2 * NRM_W + 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int RREM_W = ROOT_W + 2;
    localparam int IT_W   = $clog2(ROOT_W);
    localparam int TERM_W = ROOT_W + 1;
    localparam int PMAG_W = EIG_W + TERM_W;
    localparam int N2_W   = 2 * CNT_W;

    localparam logic [DIFF_W-1:0] NORM_LIM = DIFF_W'(1) << NRM_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PROD  = 4'd1;
    localparam logic [3:0] ST_DIVC  = 4'd2;
    localparam logic [3:0] ST_WAITC = 4'd3;
    localparam logic [3:0] ST_PREP  = 4'd4;
    localparam logic [3:0] ST_NORM  = 4'd5;
    localparam logic [3:0] ST_SQ    = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_ROOT  = 4'd8;
    localparam logic [3:0] ST_EPROD = 4'd9;
    localparam logic [3:0] ST_DIVE  = 4'd10;
    localparam logic [3:0] ST_WAITE = 4'd11;

    // Entry select for the three covariance terms.
    localparam logic [1:0] SEL_XX = 2'd0;
    localparam logic [1:0] SEL_XY = 2'd1;
    localparam logic [1:0] SEL_YY = 2'd2;

    logic [3:0]               state_reg, state_next;
    logic [1:0]               sel_reg, sel_next;
    set_t                     set_reg, set_next;
    logic [N2_W-1:0]          n2_reg, n2_next;
    logic signed [NUMC_W-1:0] num_reg, num_next;
    logic [OUT_W-1:0]         xx_reg, xx_next;
    logic [OUT_W-1:0]         xy_reg, xy_next;
    logic [OUT_W-1:0]         yy_reg, yy_next;
    logic [DIFF_W-1:0]        dmag_reg, dmag_next;
    logic [DIFF_W-1:0]        emag_reg, emag_next;
    logic                     dneg_reg, dneg_next;
    logic                     eneg_reg, eneg_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [RREM_W-1:0]        rrem_reg, rrem_next;
    logic [IT_W-1:0]          it_reg, it_next;
    logic [PMAG_W-1:0]        pmag_reg, pmag_next;
    logic                     psign_reg, psign_next;
    logic                     ovalid_reg, ovalid_next;
    logic                     ocorner_reg, ocorner_next;
    logic [OUT_W-1:0]         oxx_reg, oxx_next;
    logic [OUT_W-1:0]         oxy_reg, oxy_next;
    logic [OUT_W-1:0]         oyy_reg, oyy_next;

    // Working values.
    logic signed [CNT_W:0]    n_s;
    logic signed [SQ_W-1:0]   s_pq;
    logic signed [SUM_W-1:0]  s_p;
    logic signed [SUM_W-1:0]  s_q;
    logic signed [NUMC_W-1:0] pa;
    logic signed [NUMC_W-1:0] pb;
    logic [NUMC_W-1:0]        nmag;
    logic signed [63:0]       qv;
    logic signed [63:0]       val;
    logic [OUT_W-1:0]         val_sat;
    logic signed [DIFF_W-1:0] dd;
    logic signed [DIFF_W-1:0] ee;
    logic [RREM_W+1:0]        rem_sh;
    logic [RREM_W+1:0]        trial;
    logic signed [EIG_W:0]    dl;
    logic [EIG_W-1:0]         dl_mag;
    logic [TERM_W-1:0]        term;

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ocorner_reg;
    assign m_tdata  = {oyy_reg, oxy_reg, oxx_reg};

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        set_next     = set_reg;
        n2_next      = n2_reg;
        num_next     = num_reg;
        xx_next      = xx_reg;
        xy_next      = xy_reg;
        yy_next      = yy_reg;
        dmag_next    = dmag_reg;
        emag_next    = emag_reg;
        dneg_next    = dneg_reg;
        eneg_next    = eneg_reg;
        rad_next     = rad_reg;
        root_next    = root_reg;
        rrem_next    = rrem_reg;
        it_next      = it_reg;
        pmag_next    = pmag_reg;
        psign_next   = psign_reg;
        ovalid_next  = ovalid_reg & ~m_tready;
        ocorner_next = ocorner_reg;
        oxx_next     = oxx_reg;
        oxy_next     = oxy_reg;
        oyy_next     = oyy_reg;
        pop          = 1'b0;
        div_req      = '0;

        // Operand selection for the raw covariance entry.
        n_s = signed'({1'b0, set_reg.count});
        case (sel_reg)
            SEL_XX:
            begin
                s_pq = set_reg.sum_xx;
                s_p  = set_reg.sum_x;
                s_q  = set_reg.sum_x;
            end
            SEL_XY:
            begin
                s_pq = set_reg.sum_xy;
                s_p  = set_reg.sum_x;
                s_q  = set_reg.sum_y;
            end
            default:
            begin
                s_pq = set_reg.sum_yy;
                s_p  = set_reg.sum_y;
                s_q  = set_reg.sum_y;
            end
        endcase
        pa   = NUMC_W'(n_s) * NUMC_W'(s_pq);
        pb   = NUMC_W'(s_p) * NUMC_W'(s_q);
        nmag = num_reg[NUMC_W-1] ? NUMC_W'(-num_reg) : NUMC_W'(num_reg);

        // Signed quotient from the divider, plus eig_small for the diagonal entries in eigenvalue mode.
        qv = signed'(div_rsp.quo);
        if (state_reg == ST_WAITE)
        begin
            val = psign_reg ? -qv : qv;
            if (sel_reg != SEL_XY)
            begin
                val = val + signed'({32'b0, cfg.eig_small});
            end
        end
        else
        begin
            val = num_reg[NUMC_W-1] ? -qv : qv;
        end
        val_sat = sat_out(val);

        // Axis difference and doubled cross term.
        dd = DIFF_W'(signed'(xx_reg)) - DIFF_W'(signed'(yy_reg));
        ee = DIFF_W'(signed'(xy_reg)) <<< 1;

        // Square root digit step.
        rem_sh = {rrem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {2'b00, root_reg, 2'b01};

        // Eigenvalue spread and the per-entry factor.
        dl     = signed'({1'b0, cfg.eig_large}) - signed'({1'b0, cfg.eig_small});
        dl_mag = dl[EIG_W] ? EIG_W'(-dl) : dl[EIG_W-1:0];
        case (sel_reg)
            SEL_XX:
                term = dneg_reg ? TERM_W'(root_reg) - TERM_W'(dmag_reg[NRM_W-1:0])
                                : TERM_W'(root_reg) + TERM_W'(dmag_reg[NRM_W-1:0]);
            SEL_XY:
                term = TERM_W'(emag_reg[NRM_W-1:0]);
            default:
                term = dneg_reg ? TERM_W'(root_reg) + TERM_W'(dmag_reg[NRM_W-1:0])
                                : TERM_W'(root_reg) - TERM_W'(dmag_reg[NRM_W-1:0]);
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if ((fifo_count != '0) && !ovalid_reg)
                begin
                    pop      = 1'b1;
                    set_next = pop_data;
                    sel_next = SEL_XX;
                    n2_next  = N2_W'(pop_data.count) * N2_W'(pop_data.count);
                    if (pop_data.count < cfg.min_neighbors)
                    begin
                        ovalid_next  = 1'b1;
                        ocorner_next = 1'b1;
                        oxx_next     = ONE_Q20;
                        oxy_next     = '0;
                        oyy_next     = ONE_Q20;
                    end
                    else
                    begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD:
            begin
                num_next   = pa - pb;
                state_next = ST_DIVC;
            end
            ST_DIVC:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(nmag) + DIV_NUM_W'(n2_reg >> 1);
                div_req.den   = DIV_DEN_W'(n2_reg);
                state_next    = ST_WAITC;
            end
            ST_WAITC:
            begin
                if (div_rsp.done)
                begin
                    case (sel_reg)
                        SEL_XX:  xx_next = val_sat;
                        SEL_XY:  xy_next = val_sat;
                        default: yy_next = val_sat;
                    endcase
                    if (sel_reg == SEL_YY)
                    begin
                        if (cfg.regularize_mode)
                        begin
                            state_next = ST_PREP;
                        end
                        else
                        begin
                            ovalid_next  = 1'b1;
                            ocorner_next = 1'b0;
                            oxx_next     = xx_reg;
                            oxy_next     = xy_reg;
                            oyy_next     = val_sat;
                            state_next   = ST_IDLE;
                        end
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PREP:
            begin
                dneg_next  = dd[DIFF_W-1];
                eneg_next  = ee[DIFF_W-1];
                dmag_next  = dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
                emag_next  = ee[DIFF_W-1] ? DIFF_W'(-ee) : DIFF_W'(ee);
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // Shift both magnitudes down until each fits the root unit.
                if ((dmag_reg >= NORM_LIM) || (emag_reg >= NORM_LIM))
                begin
                    dmag_next = dmag_reg >> 1;
                    emag_next = emag_reg >> 1;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                rad_next   = RAD_W'(RAD_W'(dmag_reg[NRM_W-1:0]) * RAD_W'(dmag_reg[NRM_W-1:0]))
                           + RAD_W'(RAD_W'(emag_reg[NRM_W-1:0]) * RAD_W'(emag_reg[NRM_W-1:0]));
                root_next  = '0;
                rrem_next  = '0;
                it_next    = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rrem_next = RREM_W'(rem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rrem_next = RREM_W'(rem_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                it_next  = it_reg + 1'b1;
                if (it_reg == IT_W'(ROOT_W - 1))
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                // Isotropic case: major axis along x.
                if (root_reg == '0)
                begin
                    ovalid_next  = 1'b1;
                    ocorner_next = 1'b0;
                    oxx_next     = OUT_W'(cfg.eig_large);
                    oxy_next     = '0;
                    oyy_next     = OUT_W'(cfg.eig_small);
                    state_next   = ST_IDLE;
                end
                else
                begin
                    sel_next   = SEL_XX;
                    state_next = ST_EPROD;
                end
            end
            ST_EPROD:
            begin
                pmag_next  = PMAG_W'(dl_mag) * PMAG_W'(term);
                psign_next = (sel_reg == SEL_XY) ? (dl[EIG_W] ^ eneg_reg) : dl[EIG_W];
                state_next = ST_DIVE;
            end
            ST_DIVE:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(pmag_reg) + DIV_NUM_W'(root_reg);
                div_req.den   = DIV_DEN_W'({root_reg, 1'b0});
                state_next    = ST_WAITE;
            end
            ST_WAITE:
            begin
                if (div_rsp.done)
                begin
                    case (sel_reg)
                        SEL_XX:  xx_next = val_sat;
                        SEL_XY:  xy_next = val_sat;
                        default: yy_next = val_sat;
                    endcase
                    if (sel_reg == SEL_YY)
                    begin
                        ovalid_next  = 1'b1;
                        ocorner_next = 1'b0;
                        oxx_next     = xx_reg;
                        oxy_next     = xy_reg;
                        oyy_next     = val_sat;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_EPROD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        set_reg     <= set_next;
        n2_reg      <= n2_next;
        num_reg     <= num_next;
        xx_reg      <= xx_next;
        xy_reg      <= xy_next;
        yy_reg      <= yy_next;
        dmag_reg    <= dmag_next;
        emag_reg    <= emag_next;
        dneg_reg    <= dneg_next;
        eneg_reg    <= eneg_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rrem_reg    <= rrem_next;
        it_reg      <= it_next;
        pmag_reg    <= pmag_next;
        psign_reg   <= psign_next;
        ocorner_reg <= ocorner_next;
        oxx_reg     <= oxx_next;
        oxy_reg     <= oxy_next;
        oyy_reg     <= oyy_next;
    end

endmodule

@@ rtl/neighborhood_covariance_2d.sv @@
`timescale 1ns / 1ps

// Neighborhood covariance in 2-D. Each neighbor set arrives as a run of
// signed Q10.10 (x, y) words with tlast on the final one; one result word
// per set leaves with the 2x2 covariance in signed Q28.20 (tuser high when
// the set was too small and the identity is returned). The front end takes
// one input word per clock and hands each finished set to a two-entry
// queue; the input stalls while two finished sets wait there or are about
// to enter it. The back end finishes one set at a time using a shared
// 64-step serial divider: a raw covariance needs three divisions, and
// eigenvalue mode adds normalize shifts, a square root and three more
// divisions. Configuration writes take effect at once and belong
// between sets.
module neighborhood_covariance_2d
    import ncov_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [EIG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // coord_x [19:0], coord_y [39:20]
    input  logic             s_tlast,   // last_neighbor
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [143:0]     m_tdata,   // cov_xx [47:0], cov_xy [95:48], cov_yy [143:96]
    output logic             m_tuser    // corner_one
);

    cfg_t                  cfg_reg;
    logic                  push;
    set_t                  push_data;
    logic                  pop;
    set_t                  pop_data;
    logic [FIFO_CNT_W-1:0] fifo_count;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_neighbors   <= RST_MIN_NEIGHBORS;
            cfg_reg.regularize_mode <= 1'b0;
            cfg_reg.eig_small       <= RST_EIG_SMALL;
            cfg_reg.eig_large       <= RST_EIG_LARGE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_NEIGHBORS:   cfg_reg.min_neighbors   <= cfg_data[CNT_W-1:0];
                REG_REGULARIZE_MODE: cfg_reg.regularize_mode <= cfg_data[0];
                REG_EIG_SMALL:       cfg_reg.eig_small       <= cfg_data;
                REG_EIG_LARGE:       cfg_reg.eig_large       <= cfg_data;
                default:             cfg_reg.min_neighbors   <= cfg_reg.min_neighbors;
            endcase
        end
    end

    ncov_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .fifo_count (fifo_count),
        .push       (push),
        .push_data  (push_data)
    );

    ncov_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    ncov_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ncov_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_count (fifo_count),
        .pop_data   (pop_data),
        .pop        (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
